@@ rtl/nearest_ray_segment_hit_assert.svh @@
// Assertion macros used by the top-level RTL module
`ifndef NEAREST_RAY_SEGMENT_HIT_ASSERT_SVH
`define NEAREST_RAY_SEGMENT_HIT_ASSERT_SVH

// Check that a property holds at every clock edge out of reset
`define NRSH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds out of reset
`define NRSH_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/nrsh_pkg.sv @@
package nrsh_pkg;

    localparam int MAX_WALLS  = 64;
    localparam int COORD_BITS = 12;
    localparam int DIR_W      = 16;
    localparam int OP_W       = 2;
    localparam int WALL_ID_W  = 6;
    localparam int IDX_W      = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNT_W      = $clog2(MAX_WALLS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int DEN_W      = DIFF_W + DIR_W + 1;
    localparam int CR_W       = 2 * DIFF_W + 1;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NUM_W      = COORD_BITS + DEN_W + 1;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_CAST   = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [COORD_BITS-1:0]   wall_ax;
        logic [COORD_BITS-1:0]   wall_ay;
        logic [COORD_BITS-1:0]   wall_bx;
        logic [COORD_BITS-1:0]   wall_by;
        logic [COORD_BITS-1:0]   origin_x;
        logic [COORD_BITS-1:0]   origin_y;
        logic signed [DIR_W-1:0] ray_dx;
        logic signed [DIR_W-1:0] ray_dy;
    } in_item_t;

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] hit_x;
        logic [COORD_BITS-1:0] hit_y;
        logic [WALL_ID_W-1:0]  hit_wall;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
    } wall_t;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CALC,
        S_FIN_RD,
        S_FIN,
        S_DIVX,
        S_DIVY,
        S_DONE
    } state_t;

endpackage

@@ rtl/nrsh_wall_mem.sv @@
module nrsh_wall_mem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [nrsh_pkg::IDX_W-1:0] waddr,
    input  nrsh_pkg::wall_t           wdata,
    input  logic                      re,
    input  logic [nrsh_pkg::IDX_W-1:0] raddr,
    output nrsh_pkg::wall_t           rdata
);
    import nrsh_pkg::*;

    wall_t mem [MAX_WALLS];
    wall_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nrsh_mul.sv @@
module nrsh_mul (
    input  logic                              clk,
    input  logic signed [nrsh_pkg::MUL_W-1:0]  a,
    input  logic signed [nrsh_pkg::MUL_W-1:0]  b,
    output logic signed [nrsh_pkg::PROD_W-1:0] p
);
    import nrsh_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ rtl/nrsh_div.sv @@
module nrsh_div (
    input  logic                clk,
    input  logic                rst_n,
    input  nrsh_pkg::div_req_t  req,
    output nrsh_pkg::div_rsp_t  rsp
);
    import nrsh_pkg::*;

    localparam int STEP_W = $clog2(COORD_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [NUM_W-1:0]      dsr_reg, dsr_next;
    logic [COORD_BITS-1:0] quo_reg, quo_next;
    logic                  fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        fits      = rem_reg >= dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.num;
            dsr_next  = NUM_W'(req.den) << (COORD_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            quo_next = {quo_reg[COORD_BITS-2:0], fits};
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(COORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ rtl/nearest_ray_segment_hit.sv @@
// Nearest ray/segment hit.
// Input channel in_valid/in_ready/in_item carries clear, append and cast
// transactions; output channel out_valid/out_ready/out_item returns one
// result per cast and none for clear, append or an unused operation code.
// A cast walks the stored walls one by one through a single registered
// 32x32 multiplier; each wall hit after the first is also compared with
// the best hit so far. The cast then rebuilds the winning point and divides
// out x and y with a 12-step restoring divider. When no wall is hit that
// part is skipped, and a cast on an empty table goes straight to its result.
// in_ready is high only while no cast is in progress. A finished result sits
// in the output register; a stalled receiver holds it there, and a further
// cast then waits at its last cycle until the register frees up.
// Reset empties the wall table and clears the output valid flag.
module nearest_ray_segment_hit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nrsh_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nrsh_pkg::out_item_t  out_item
);
    import nrsh_pkg::*;

    `include "nearest_ray_segment_hit_assert.svh"

    state_t                   state_reg, state_next;
    logic [3:0]               step_reg, step_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     found_reg, found_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_item_reg, out_item_next;

    logic [COORD_BITS-1:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic signed [DIR_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [DEN_W-1:0]  den_reg, den_next, tn_reg, tn_next;
    logic signed [CR_W-1:0]   cr_reg, cr_next;
    logic signed [DEN_W-1:0]  bden_reg, bden_next, btn_reg, btn_next;
    logic signed [CR_W-1:0]   bcr_reg, bcr_next;
    logic [IDX_W-1:0]         bidx_reg, bidx_next;
    logic [NUM_W-1:0]         numx_reg, numx_next, numy_reg, numy_next;
    logic [COORD_BITS-1:0]    hx_reg, hx_next;

    logic                     mem_we, mem_re;
    logic [IDX_W-1:0]         mem_raddr;
    wall_t                    wall_in, rd;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic signed [DIFF_W-1:0] dab_x, dab_y, dao_x, dao_y, dba_x, dba_y;
    logic signed [CR_W-1:0]   cr_raw;
    logic signed [PROD_W-1:0] sum;
    logic                     advance, valid_hit;

    assign wall_in = '{ax: in_item.wall_ax, ay: in_item.wall_ay,
                       bx: in_item.wall_bx, by: in_item.wall_by};

    nrsh_wall_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wall_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    nrsh_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    nrsh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            j_reg         <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            j_reg         <= j_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        tn_reg       <= tn_next;
        cr_reg       <= cr_next;
        bden_reg     <= bden_next;
        btn_reg      <= btn_next;
        bcr_reg      <= bcr_next;
        bidx_reg     <= bidx_next;
        numx_reg     <= numx_next;
        numy_reg     <= numy_next;
        hx_reg       <= hx_next;
    end

    always_comb
    begin
        dab_x  = signed'({1'b0, rd.ax}) - signed'({1'b0, rd.bx});
        dab_y  = signed'({1'b0, rd.ay}) - signed'({1'b0, rd.by});
        dao_x  = signed'({1'b0, rd.ax}) - signed'({1'b0, ox_reg});
        dao_y  = signed'({1'b0, rd.ay}) - signed'({1'b0, oy_reg});
        dba_x  = -dab_x;
        dba_y  = -dab_y;
        cr_raw = CR_W'(prod - acc_reg);
        sum    = acc_reg + prod;
        valid_hit = (den_reg != '0) && (tn_reg > 0) && (tn_reg < den_reg) && (cr_reg > 0);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg + 4'd1;
        j_next         = j_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        den_next       = den_reg;
        tn_next        = tn_reg;
        cr_next        = cr_reg;
        bden_next      = bden_reg;
        btn_next       = btn_reg;
        bcr_next       = bcr_reg;
        bidx_next      = bidx_reg;
        numx_next      = numx_reg;
        numy_next      = numy_reg;
        hx_next        = hx_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = j_reg[IDX_W-1:0];
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;
        advance        = 1'b0;
        in_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_WALLS))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_CAST:
                        begin
                            ox_next    = in_item.origin_x;
                            oy_next    = in_item.origin_y;
                            dx_next    = in_item.ray_dx;
                            dy_next    = in_item.ray_dy;
                            found_next = 1'b0;
                            j_next     = '0;
                            state_next = (count_reg == '0) ? S_DONE : S_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                step_next  = '0;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = MUL_W'(dab_y);
                        mul_b = MUL_W'(dx_reg);
                    end
                    4'd1:
                    begin
                        mul_a    = MUL_W'(dab_x);
                        mul_b    = MUL_W'(dy_reg);
                        acc_next = prod;
                    end
                    4'd2:
                    begin
                        mul_a    = MUL_W'(dao_y);
                        mul_b    = MUL_W'(dx_reg);
                        den_next = DEN_W'(acc_reg - prod);
                    end
                    4'd3:
                    begin
                        mul_a    = MUL_W'(dao_x);
                        mul_b    = MUL_W'(dy_reg);
                        acc_next = prod;
                    end
                    4'd4:
                    begin
                        mul_a   = MUL_W'(dab_x);
                        mul_b   = MUL_W'(dao_y);
                        tn_next = DEN_W'(acc_reg - prod);
                    end
                    4'd5:
                    begin
                        mul_a    = MUL_W'(dab_y);
                        mul_b    = MUL_W'(dao_x);
                        acc_next = prod;
                    end
                    4'd6:
                    begin
                        if (den_reg < 0)
                        begin
                            den_next = -den_reg;
                            tn_next  = -tn_reg;
                            cr_next  = -cr_raw;
                        end
                        else
                        begin
                            cr_next = cr_raw;
                        end
                    end
                    4'd7:
                    begin
                        mul_a = MUL_W'(cr_reg);
                        mul_b = MUL_W'(bden_reg);
                        if (!valid_hit)
                        begin
                            advance = 1'b1;
                        end
                        else if (!found_reg)
                        begin
                            found_next = 1'b1;
                            bden_next  = den_reg;
                            btn_next   = tn_reg;
                            bcr_next   = cr_reg;
                            bidx_next  = j_reg[IDX_W-1:0];
                            advance    = 1'b1;
                        end
                    end
                    4'd8:
                    begin
                        mul_a    = MUL_W'(bcr_reg);
                        mul_b    = MUL_W'(den_reg);
                        acc_next = prod;
                    end
                    default:
                    begin
                        // strictly nearer only: earlier wall keeps a tie
                        if (acc_reg < prod)
                        begin
                            bden_next = den_reg;
                            btn_next  = tn_reg;
                            bcr_next  = cr_reg;
                            bidx_next = j_reg[IDX_W-1:0];
                        end
                        advance = 1'b1;
                    end
                endcase
            end
            S_FIN_RD:
            begin
                mem_raddr = bidx_reg;
                step_next = '0;
                if (found_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FIN:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = MUL_W'({1'b0, rd.ax});
                        mul_b = MUL_W'(bden_reg);
                    end
                    4'd1:
                    begin
                        mul_a    = MUL_W'(btn_reg);
                        mul_b    = MUL_W'(dba_x);
                        acc_next = prod;
                    end
                    4'd2:
                    begin
                        mul_a     = MUL_W'({1'b0, rd.ay});
                        mul_b     = MUL_W'(bden_reg);
                        numx_next = (sum < 0) ? '0 : NUM_W'(sum);
                    end
                    4'd3:
                    begin
                        mul_a    = MUL_W'(btn_reg);
                        mul_b    = MUL_W'(dba_y);
                        acc_next = prod;
                    end
                    default:
                    begin
                        numy_next     = (sum < 0) ? '0 : NUM_W'(sum);
                        div_req.start = 1'b1;
                        div_req.num   = numx_reg;
                        div_req.den   = DEN_W'(bden_reg);
                        state_next    = S_DIVX;
                    end
                endcase
            end
            S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    hx_next       = div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.num   = numy_reg;
                    div_req.den   = DEN_W'(bden_reg);
                    state_next    = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.hit      = found_reg;
                    out_item_next.hit_x    = found_reg ? hx_reg : '0;
                    out_item_next.hit_y    = found_reg ? div_rsp.quo : '0;
                    out_item_next.hit_wall = found_reg ? WALL_ID_W'(bidx_reg) : '0;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            j_next     = j_reg + CNT_W'(1);
            state_next = ((j_reg + CNT_W'(1)) == count_reg) ? S_FIN_RD : S_RD;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `NRSH_NEVER(a_count_in_range, count_reg > CNT_W'(MAX_WALLS), "wall count overflow")
    `NRSH_ASSERT(a_best_stored, (found_reg && state_reg != S_IDLE) |-> (CNT_W'(bidx_reg) < count_reg), "best wall beyond table")
    `NRSH_ASSERT(a_found_holds, (found_reg && !(in_valid && in_ready)) |=> found_reg, "hit lost mid cast")
    `NRSH_ASSERT(a_div_start, div_req.start |-> (state_reg == S_FIN || state_reg == S_DIVX), "divider started out of turn")

endmodule

@@ dv/nrsh_checker.sv @@
module nrsh_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  nrsh_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_ready,
    input  nrsh_pkg::out_item_t out_item,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nrsh_pkg::*;

    wall_t     walls [MAX_WALLS];
    int        wall_cnt;
    out_item_t hits_due [$];

    function automatic out_item_t nearest_hit(input in_item_t it);
        longint    ox, oy, dx, dy, ax, ay, bx, by, den, tn, un, bu, bd, nx, ny;
        logic [127:0] lhs, rhs;
        bit        found;
        out_item_t res;
        res = '0;
        found = 0;
        bu = 0;
        bd = 1;
        ox = longint'(it.origin_x);
        oy = longint'(it.origin_y);
        dx = longint'(it.ray_dx);
        dy = longint'(it.ray_dy);
        for (int j = 0; j < wall_cnt; j++)
        begin
            ax = longint'(walls[j].ax);
            ay = longint'(walls[j].ay);
            bx = longint'(walls[j].bx);
            by = longint'(walls[j].by);
            den = (ay - by) * dx - (ax - bx) * dy;
            if (den == 0)
                continue;
            tn = (ay - oy) * dx - (ax - ox) * dy;
            un = -((ax - bx) * (ay - oy) - (ay - by) * (ax - ox)) * 16384;
            if (den < 0)
            begin
                den = -den;
                tn = -tn;
                un = -un;
            end
            if (!(tn > 0 && tn < den && un > 0))
                continue;
            lhs = 128'(un) * 128'(bd);
            rhs = 128'(bu) * 128'(den);
            if (!found || lhs < rhs)
            begin
                found = 1;
                bu = un;
                bd = den;
                nx = ax * den + tn * (bx - ax);
                ny = ay * den + tn * (by - ay);
                if (nx < 0)
                    nx = 0;
                if (ny < 0)
                    ny = 0;
                res.hit = 1'b1;
                res.hit_x = COORD_BITS'(nx / den);
                res.hit_y = COORD_BITS'(ny / den);
                res.hit_wall = WALL_ID_W'(j);
            end
        end
        return res;
    endfunction

    assign pending = hits_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_cnt <= 0;
            errors <= 0;
            hits_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (hits_due.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %p", $time, out_item);
                    errors <= errors + 1;
                end
                else
                begin
                    out_item_t e;
                    e = hits_due.pop_front();
                    if (e.hit !== out_item.hit)
                        $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_item.hit);
                    if (e.hit_x !== out_item.hit_x)
                        $display("%0t: hit_x expected %0d actual %0d",
                                 $time, e.hit_x, out_item.hit_x);
                    if (e.hit_y !== out_item.hit_y)
                        $display("%0t: hit_y expected %0d actual %0d",
                                 $time, e.hit_y, out_item.hit_y);
                    if (e.hit_wall !== out_item.hit_wall)
                        $display("%0t: hit_wall expected %0d actual %0d",
                                 $time, e.hit_wall, out_item.hit_wall);
                    if (e !== out_item)
                        errors <= errors + 1;
                end
            end
            if (in_valid && in_ready)
            begin
                case (in_item.operation)
                    OP_CLEAR:  wall_cnt <= 0;
                    OP_APPEND:
                        if (wall_cnt < MAX_WALLS)
                        begin
                            walls[wall_cnt] <= '{in_item.wall_ax, in_item.wall_ay,
                                                 in_item.wall_bx, in_item.wall_by};
                            wall_cnt <= wall_cnt + 1;
                        end
                    OP_CAST:   hits_due.insert(hits_due.size(), nearest_hit(in_item));
                    default:   ;
                endcase
            end
        end
    end
endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nrsh_pkg::*;

    localparam int N_ITEMS    = 1450;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN      = 1000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    int        errors, pending;
    int        tx_pct = 13, rx_pct = 83;
    int        sent = 0, casts = 0, idle_cycles = 0;
    wall_t     aim [$];

    nearest_ray_segment_hit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    nrsh_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("[nearest_ray_segment_hit] ERROR");
            $finish;
        end
    end

    task automatic send(input in_item_t it);
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (it.operation == OP_CAST)
            casts++;
        if (sent == N_ITEMS / 3)
        begin
            tx_pct = 83;
            rx_pct = 13;
        end
        if (sent == 2 * N_ITEMS / 3)
        begin
            tx_pct = 0;
            rx_pct = 0;
        end
    endtask

    task automatic clear_walls();
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_CLEAR;
        aim.delete();
        send(it);
    endtask

    task automatic add_wall(input int ax, ay, bx, by);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_APPEND;
        it.wall_ax = COORD_BITS'(ax);
        it.wall_ay = COORD_BITS'(ay);
        it.wall_bx = COORD_BITS'(bx);
        it.wall_by = COORD_BITS'(by);
        if (aim.size() < MAX_WALLS)
            aim.insert(aim.size(), '{it.wall_ax, it.wall_ay, it.wall_bx, it.wall_by});
        send(it);
    endtask

    task automatic cast(input int ox, oy, dx, dy);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_CAST;
        it.origin_x = COORD_BITS'(ox);
        it.origin_y = COORD_BITS'(oy);
        it.ray_dx = DIR_W'(dx);
        it.ray_dy = DIR_W'(dy);
        send(it);
    endtask

    task automatic aimed_cast();
        int ox, oy, k, f, tx, ty, vx, vy, m;
        ox = $urandom_range(4095);
        oy = $urandom_range(4095);
        if (aim.size() == 0 || $urandom_range(9) == 0)
        begin
            cast(ox, oy, $urandom, $urandom);
            return;
        end
        k = $urandom_range(aim.size() - 1);
        f = $urandom_range(1, 15);
        tx = int'(aim[k].ax) + (int'(aim[k].bx) - int'(aim[k].ax)) * f / 16;
        ty = int'(aim[k].ay) + (int'(aim[k].by) - int'(aim[k].ay)) * f / 16;
        vx = tx - ox;
        vy = ty - oy;
        m = (vx < 0 ? -vx : vx) > (vy < 0 ? -vy : vy) ? (vx < 0 ? -vx : vx)
                                                      : (vy < 0 ? -vy : vy);
        if (m == 0)
            m = 1;
        cast(ox, oy, vx * 16384 / m, vy * 16384 / m);
    endtask

    initial
    begin
        in_item_t junk;
        int nw;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cast(100, 100, 16384, 0);
        add_wall(0, 0, 4095, 4095);
        add_wall(4095, 0, 0, 4095);
        add_wall(2000, 0, 2000, 4095);
        cast(0, 2048, 16384, 0);
        cast(4095, 2048, -16384, 0);
        cast(2048, 0, 0, 16384);
        cast(1000, 1000, 0, 0);
        cast(3000, 100, -16384, -16384);
        cast(3000, 100, -32768, 32767);
        add_wall(10, 10, 500, 10);
        cast(0, 10, 16384, 0);
        cast(10, 10, 16384, 0);
        junk = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        junk.operation = OP_RSVD;
        send(junk);
        clear_walls();
        cast(0, 2048, 16384, 0);
        for (int i = 0; i < MAX_WALLS + 3; i++)
            add_wall(100 + i * 60, 0, 100 + i * 60, 4095);
        cast(0, 2048, 16384, 0);
        cast(4095, 2048, -16384, 0);

        while (sent < N_ITEMS)
        begin
            if ($urandom_range(15) == 0)
            begin
                junk = in_item_t'({$urandom, $urandom, $urandom, $urandom});
                send(junk);
                continue;
            end
            clear_walls();
            nw = ($urandom_range(19) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
            for (int i = 0; i < nw; i++)
                add_wall($urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095));
            repeat ($urandom_range(1, 6))
                aimed_cast();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("Sent %0d transactions, %0d of them casts, over three handshake phases.",
                 sent, casts);
        if (errors == 0)
            $display("[nearest_ray_segment_hit] OK");
        else
            $display("[nearest_ray_segment_hit] ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/nrsh_pkg.sv
rtl/nrsh_wall_mem.sv
rtl/nrsh_mul.sv
rtl/nrsh_div.sv
rtl/nearest_ray_segment_hit.sv
dv/nrsh_checker.sv
dv/tb.sv
